/* sv/nsf_pkg.sv */
// ----------------------------------------------------------------------------
// nsf_pkg
// Shared constants, types and byte-class helpers for the sentence framer.
// ----------------------------------------------------------------------------
package nsf_pkg;

  // Line store geometry
  localparam int LINE_MAX = 64;
  localparam int ADDR_W   = $clog2(LINE_MAX);
  localparam int CNT_W    = $clog2(LINE_MAX + 1);
  localparam int BYTE_W   = 7;

  // Framing characters
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_BANG   = 8'h21;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_DATA,
    ST_CS1,
    ST_CS2,
    ST_DUMP
  } phase_t;

  function automatic logic is_printable(input logic [7:0] c);
    is_printable = c inside {[8'h20:8'h7E]};
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic is_start(input logic [7:0] c);
    is_start = (c == CHAR_DOLLAR) || (c == CHAR_BANG);
  endfunction

endpackage

/* sv/nsf_ram.sv */
// ----------------------------------------------------------------------------
// nsf_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module nsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Hold read data until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* sv/nmea_sentence_framer_unit.sv */
// ----------------------------------------------------------------------------
// nmea_sentence_framer_unit
// Frames NMEA 0183 sentences from a received byte stream. While framing, the
// block takes one byte request every cycle and writes it into a 64-entry line
// memory. A '$' or '!' opens a line; printable bytes follow up to '*', then
// exactly two hex digits. A bad byte, a bad checksum digit or a line longer
// than the memory drops the line silently (the offending byte is never taken
// as a new start). On the second checksum digit the line is read back out of
// the memory through its single read port, one byte per cycle while out_stall
// is low, start byte first, with last_of_sentence set on the final digit.
// During that readout in_stall is high, so no new byte is taken until the
// final read of the line has been issued.
// The checksum value is not verified.
// ----------------------------------------------------------------------------
module nmea_sentence_framer_unit (
  input  logic       clk,
  input  logic       rst_n,
  // Received bytes
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // Sentence bytes
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_sentence_byte,
  output logic       out_last_of_sentence
);

  // Framing phase and line bookkeeping
  nsf_pkg::phase_t              state_r, state_nxt;
  logic [nsf_pkg::CNT_W-1:0]    fill_r, fill_nxt;
  logic [nsf_pkg::CNT_W-1:0]    len_r, len_nxt;
  logic [nsf_pkg::CNT_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic [nsf_pkg::CNT_W-1:0]    rd_cnt_inc;

  // Read pipeline: pv_r marks unconsumed data on the RAM read port
  logic                         pv_r, pv_nxt;
  logic                         pv_last_r, pv_last_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [nsf_pkg::BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                         out_last_r, out_last_nxt;

  // RAM ports
  logic                         ram_we;
  logic [nsf_pkg::ADDR_W-1:0]   ram_waddr;
  logic [nsf_pkg::BYTE_W-1:0]   ram_wdata;
  logic                         ram_re;
  logic [nsf_pkg::ADDR_W-1:0]   ram_raddr;
  logic [nsf_pkg::BYTE_W-1:0]   ram_rdata;

  // Handshake and byte classes
  logic                         acc;
  logic                         full;
  logic                         c_print;
  logic                         c_hex;
  logic                         c_start;
  logic                         c_star;
  logic                         move;
  logic                         issue;
  logic                         issue_last;

  assign in_stall   = (state_r == nsf_pkg::ST_DUMP);
  assign acc        = in_valid && !in_stall;
  assign full       = (fill_r == nsf_pkg::CNT_W'(nsf_pkg::LINE_MAX));
  assign c_print    = nsf_pkg::is_printable(in_rx_byte);
  assign c_hex      = nsf_pkg::is_hex(in_rx_byte);
  assign c_start    = nsf_pkg::is_start(in_rx_byte);
  assign c_star     = (in_rx_byte == nsf_pkg::CHAR_STAR);

  // Advance the read pipeline: the output register takes RAM data when it is
  // empty or being drained; during readout a new read is issued whenever the
  // RAM data slot will be free at the next edge.
  assign move       = pv_r && (!out_valid_r || !out_stall);
  assign issue      = (state_r == nsf_pkg::ST_DUMP) && (!pv_r || move);
  assign rd_cnt_inc = rd_cnt_r + nsf_pkg::CNT_W'(1);
  assign issue_last = issue && (rd_cnt_inc == len_r);

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nsf_pkg::ST_WAIT: begin
        if (acc && c_start) begin
          state_nxt = nsf_pkg::ST_DATA;
        end
      end
      nsf_pkg::ST_DATA: begin
        if (acc) begin
          if (!c_print || full) begin
            state_nxt = nsf_pkg::ST_WAIT;
          end else if (c_star) begin
            state_nxt = nsf_pkg::ST_CS1;
          end
        end
      end
      nsf_pkg::ST_CS1: begin
        if (acc) begin
          state_nxt = (c_hex && !full) ? nsf_pkg::ST_CS2 : nsf_pkg::ST_WAIT;
        end
      end
      nsf_pkg::ST_CS2: begin
        if (acc) begin
          state_nxt = (c_hex && !full) ? nsf_pkg::ST_DUMP : nsf_pkg::ST_WAIT;
        end
      end
      nsf_pkg::ST_DUMP: begin
        // Leave once the final byte has been read; the pipeline drains alone
        if (issue_last) begin
          state_nxt = nsf_pkg::ST_WAIT;
        end
      end
      default: begin
        state_nxt = nsf_pkg::ST_WAIT;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output logic: line memory writes, counters and readout reads
  // --------------------------------------------------------------------------
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = fill_r[nsf_pkg::ADDR_W-1:0];
    ram_wdata  = in_rx_byte[nsf_pkg::BYTE_W-1:0];
    ram_re     = 1'b0;
    ram_raddr  = rd_cnt_r[nsf_pkg::ADDR_W-1:0];
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    rd_cnt_nxt = rd_cnt_r;
    case (state_r)
      nsf_pkg::ST_WAIT: begin
        if (acc && c_start) begin
          // Open a fresh line at entry zero
          ram_we    = 1'b1;
          ram_waddr = '0;
          fill_nxt  = nsf_pkg::CNT_W'(1);
        end
      end
      nsf_pkg::ST_DATA: begin
        if (acc) begin
          if (c_print && !full) begin
            ram_we   = 1'b1;
            fill_nxt = fill_r + nsf_pkg::CNT_W'(1);
          end else begin
            fill_nxt = '0;
          end
        end
      end
      nsf_pkg::ST_CS1: begin
        if (acc) begin
          if (c_hex && !full) begin
            ram_we   = 1'b1;
            fill_nxt = fill_r + nsf_pkg::CNT_W'(1);
          end else begin
            fill_nxt = '0;
          end
        end
      end
      nsf_pkg::ST_CS2: begin
        if (acc) begin
          fill_nxt = '0;
          if (c_hex && !full) begin
            // Final digit: store it and arm the readout
            ram_we     = 1'b1;
            len_nxt    = fill_r + nsf_pkg::CNT_W'(1);
            rd_cnt_nxt = '0;
          end
        end
      end
      nsf_pkg::ST_DUMP: begin
        if (issue) begin
          ram_re     = 1'b1;
          rd_cnt_nxt = rd_cnt_inc;
        end
      end
      default: begin
        fill_nxt = '0;
      end
    endcase
  end

  // Read data slot and output register
  always_comb begin
    pv_nxt        = pv_r;
    pv_last_nxt   = pv_last_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = move || (out_valid_r && out_stall);
    if (move) begin
      out_byte_nxt = ram_rdata;
      out_last_nxt = pv_last_r;
      pv_nxt       = 1'b0;
    end
    if (issue) begin
      pv_nxt      = 1'b1;
      pv_last_nxt = issue_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nsf_pkg::ST_WAIT;
      fill_r      <= '0;
      len_r       <= '0;
      rd_cnt_r    <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    pv_last_r  <= pv_last_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  nsf_ram #(
    .WIDTH (nsf_pkg::BYTE_W),
    .DEPTH (nsf_pkg::LINE_MAX)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid            = out_valid_r;
  assign out_sentence_byte    = out_byte_r;
  assign out_last_of_sentence = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Writes and reads of the line memory never overlap
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("line memory written and read in the same cycle");

  // Fill count never passes the memory depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= nsf_pkg::CNT_W'(nsf_pkg::LINE_MAX))
    else $error("fill count beyond line memory depth");

  // A sentence being read out is at least "$*hh" long and fits the memory
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nsf_pkg::ST_DUMP) |->
      (len_r >= nsf_pkg::CNT_W'(4)) && (len_r <= nsf_pkg::CNT_W'(nsf_pkg::LINE_MAX)))
    else $error("sentence length out of range during readout");

  // Unconsumed read data is never overwritten
  a_pv_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pv_r && !move) |-> !ram_re)
    else $error("read issued over unconsumed read data");

  // A readout always ends with the last marker on the final byte moved
  a_last_on_exit: assert property (@(posedge clk) disable iff (!rst_n)
    issue_last |=> (pv_r && pv_last_r))
    else $error("final read of a sentence lacks the last marker");

endmodule
